// ----- design/ixcs_pkg.sv -----
// ----------------------------------------------------------------------------
// ixcs_pkg
// Shared types and constants for the XMI chunk scanner: IFF tags, parser
// phases, chunk kinds and the result record that travels to the output queue.
// ----------------------------------------------------------------------------
package ixcs_pkg;

	// Default width of the byte position counter
	localparam int POS_BITS_DEF = 32;

	// Result queue depth (entries)
	localparam int FIFO_DEPTH = 8;

	// File length register width
	localparam int LEN_BITS = 32;

	// IFF four-character codes, big-endian
	localparam logic [31:0] TAG_FORM = 32'h464F_524D;
	localparam logic [31:0] TAG_XDIR = 32'h5844_4952;
	localparam logic [31:0] TAG_INFO = 32'h494E_464F;
	localparam logic [31:0] TAG_XMID = 32'h584D_4944;

	// Header length and chunk header length in bytes
	localparam int HDR_BYTES  = 12;
	localparam int CHDR_BYTES = 8;

	// Record kinds
	localparam logic REC_SEQ     = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CHDR   = 3'd1,
		PH_BODY   = 3'd2,
		PH_STOP   = 3'd3,
		PH_BAD    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_INFO  = 2'd1,
		KIND_FORM  = 2'd2
	} kind_t;

	// One result item
	typedef struct packed {
		logic        record_kind;
		logic [31:0] seq_offset;
		logic [31:0] seq_size;
		logic        file_valid;
		logic [15:0] seq_total;
		logic [15:0] timbre_total;
		logic [15:0] seqs_found;
		logic        last_result;
	} rec_t;

	// Write strobes from the parser into the result queue
	typedef struct packed {
		logic wr_a;
		logic wr_b;
	} push_t;

endpackage

// ----- design/iff_xmi_chunk_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and the parser writes
// the results for that byte into the queue, whose head is offered on the output.
// Throughput: one byte per cycle; the input stalls only while the result
// queue lacks room for two more records from each byte in flight.
// Reset: arst_n clears parser state, the queue and file_length; after each
// last byte the parser returns to its reset state (file_length is kept).
// ----------------------------------------------------------------------------
// iff_xmi_chunk_scanner_unit
// Top level: input register, config register, parser and result queue.
// ----------------------------------------------------------------------------
module iff_xmi_chunk_scanner_unit #(
	parameter int POS_BITS = ixcs_pkg::POS_BITS_DEF,
	parameter int DEPTH    = ixcs_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_kind,
	output logic [31:0] seq_offset,
	output logic [31:0] seq_size,
	output logic        file_valid,
	output logic [15:0] seq_total,
	output logic [15:0] timbre_total,
	output logic [15:0] seqs_found,
	output logic        last_result
);

	localparam int CW = $clog2(DEPTH) + 1;

	logic [31:0]     file_length_q;
	logic            vld_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            in_xfer;
	ixcs_pkg::push_t push;
	ixcs_pkg::rec_t  rec_a, rec_b, head;
	logic [CW-1:0]   count;
	logic [CW:0]     reserve;

	// File length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_wr_en) begin
			file_length_q <= cfg_wr_data;
		end
	end

	// Room for two records from the byte in flight and two from the next
	assign reserve  = (CW+1)'(count) + (vld_s1 ? (CW+1)'(2) : '0);
	assign in_ready = reserve <= (CW+1)'(DEPTH - 2);
	assign in_xfer  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ixcs_parser #(
		.POS_BITS (POS_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_vld    (vld_s1),
		.byte_val    (byte_s1),
		.byte_last   (last_s1),
		.file_length (file_length_q),
		.push        (push),
		.rec_a       (rec_a),
		.rec_b       (rec_b)
	);

	ixcs_out_fifo #(
		.DEPTH (DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_a     (rec_a),
		.rec_b     (rec_b),
		.pop       (out_ready),
		.not_empty (out_valid),
		.head      (head),
		.count     (count)
	);

	assign record_kind  = head.record_kind;
	assign seq_offset   = head.seq_offset;
	assign seq_size     = head.seq_size;
	assign file_valid   = head.file_valid;
	assign seq_total    = head.seq_total;
	assign timbre_total = head.timbre_total;
	assign seqs_found   = head.seqs_found;
	assign last_result  = head.last_result;

endmodule

// ----- design/ixcs_parser.sv -----
// ----------------------------------------------------------------------------
// ixcs_parser
// Byte-wise IFF parser. Consumes one registered byte per cycle, updates the
// header/chunk state and produces up to two result records for that byte.
// ----------------------------------------------------------------------------
module ixcs_parser #(
	parameter int POS_BITS = ixcs_pkg::POS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_vld,
	input  logic [7:0]                     byte_val,
	input  logic                           byte_last,
	input  logic [ixcs_pkg::LEN_BITS-1:0]  file_length,
	output ixcs_pkg::push_t                push,
	output ixcs_pkg::rec_t                 rec_a,
	output ixcs_pkg::rec_t                 rec_b
);

	localparam int WW = 34; // wide enough for position + 1 + chunk size

	// Parser state
	ixcs_pkg::phase_t      phase_q, phase_u, phase_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [31:0]           tag_q, tag_d;
	logic [31:0]           size_q, size_d;
	logic [31:0]           bleft_q, bleft_d;
	ixcs_pkg::kind_t       kind_q, kind_d;
	logic [2:0]            bidx_q, bidx_d;
	logic [POS_BITS:0]     bstart_q, bstart_d;
	logic [15:0]           info_sc_q, info_sc_d;
	logic [15:0]           info_tc_q, info_tc_d;
	logic [15:0]           found_q, found_d;

	// Shared decode of the current byte
	logic [31:0]   tag_sh, size_sh, blen, bleft_dec;
	logic [WW-1:0] pos_w, flen_w, bstart_w;
	logic          hdr_form_bad, hdr_done, hdr_ok;
	logic          chdr_no_room, chdr_done, overrun;
	logic          body_end, fourth, xmid_hit;
	logic [15:0]   found_inc;
	logic          header_ok;

	assign tag_sh       = {tag_q[23:0], byte_val};
	assign size_sh      = {size_q[23:0], byte_val};
	assign pos_w        = WW'(pos_q);
	assign flen_w       = WW'(file_length);
	assign bstart_w     = pos_w + WW'(1);
	assign hdr_form_bad = (pos_q == POS_BITS'(3)) && (tag_sh != ixcs_pkg::TAG_FORM);
	assign hdr_done     = pos_q >= POS_BITS'(ixcs_pkg::HDR_BYTES - 1);
	assign hdr_ok       = (tag_sh == ixcs_pkg::TAG_XDIR)
	                   && (file_length >= ixcs_pkg::LEN_BITS'(ixcs_pkg::HDR_BYTES));
	assign chdr_no_room = (bidx_q == 3'd0)
	                   && ((pos_w + WW'(ixcs_pkg::CHDR_BYTES)) > flen_w);
	assign chdr_done    = bidx_q == 3'(ixcs_pkg::CHDR_BYTES - 1);
	assign overrun      = (bstart_w + WW'(size_sh)) > flen_w;
	assign blen         = size_sh + {31'd0, size_sh[0]};
	assign bleft_dec    = bleft_q - 32'd1;
	assign body_end     = bleft_dec == 32'd0;
	assign fourth       = bidx_q == 3'd3;
	assign xmid_hit     = byte_vld && (phase_q == ixcs_pkg::PH_BODY) && fourth
	                   && (kind_q == ixcs_pkg::KIND_FORM) && (tag_sh == ixcs_pkg::TAG_XMID);
	assign found_inc    = (found_q == 16'hFFFF) ? found_q : found_q + 16'd1;

	// Next phase
	always_comb begin
		phase_u = phase_q;
		case (phase_q)
			ixcs_pkg::PH_HEADER: begin
				if (hdr_form_bad) begin
					phase_u = ixcs_pkg::PH_BAD;
				end else if (hdr_done) begin
					phase_u = hdr_ok ? ixcs_pkg::PH_CHDR : ixcs_pkg::PH_BAD;
				end
			end
			ixcs_pkg::PH_CHDR: begin
				if (chdr_no_room) begin
					phase_u = ixcs_pkg::PH_STOP;
				end else if (chdr_done) begin
					if (overrun) begin
						phase_u = ixcs_pkg::PH_STOP;
					end else begin
						phase_u = (blen == 32'd0) ? ixcs_pkg::PH_CHDR : ixcs_pkg::PH_BODY;
					end
				end
			end
			ixcs_pkg::PH_BODY: begin
				if (body_end) begin
					phase_u = ixcs_pkg::PH_CHDR;
				end
			end
			default: phase_u = phase_q;
		endcase
		phase_d = phase_q;
		if (byte_vld) begin
			phase_d = byte_last ? ixcs_pkg::PH_HEADER : phase_u;
		end
	end

	// Datapath registers
	always_comb begin
		pos_d     = pos_q;
		tag_d     = tag_q;
		size_d    = size_q;
		bleft_d   = bleft_q;
		kind_d    = kind_q;
		bidx_d    = bidx_q;
		bstart_d  = bstart_q;
		info_sc_d = info_sc_q;
		info_tc_d = info_tc_q;
		found_d   = found_q;
		if (byte_vld) begin
			case (phase_q)
				ixcs_pkg::PH_HEADER: tag_d = tag_sh;
				ixcs_pkg::PH_CHDR: begin
					if (!chdr_no_room) begin
						if (bidx_q < 3'd4) begin
							tag_d = tag_sh;
						end else begin
							size_d = size_sh;
						end
						bidx_d = bidx_q + 3'd1;
						if (chdr_done) begin
							bstart_d = bstart_w[POS_BITS:0];
							bidx_d   = 3'd0;
							if (!overrun) begin
								kind_d = ixcs_pkg::KIND_OTHER;
								if (size_sh >= 32'd4) begin
									if (tag_q == ixcs_pkg::TAG_INFO) begin
										kind_d = ixcs_pkg::KIND_INFO;
									end else if (tag_q == ixcs_pkg::TAG_FORM) begin
										kind_d = ixcs_pkg::KIND_FORM;
									end
								end
								bleft_d = blen;
							end
						end
					end
				end
				ixcs_pkg::PH_BODY: begin
					if (bidx_q < 3'd4) begin
						tag_d  = tag_sh;
						bidx_d = bidx_q + 3'd1;
						if (fourth && (kind_q == ixcs_pkg::KIND_INFO)) begin
							info_sc_d = tag_sh[31:16];
							info_tc_d = tag_sh[15:0];
						end
						if (xmid_hit) begin
							found_d = found_inc;
						end
					end
					bleft_d = bleft_dec;
					if (body_end) begin
						bidx_d = 3'd0;
					end
				end
				default: ;
			endcase
			if (pos_q != '1) begin
				pos_d = pos_q + POS_BITS'(1);
			end
			// end of file: back to the reset state for the next file
			if (byte_last) begin
				pos_d     = '0;
				tag_d     = '0;
				size_d    = '0;
				bleft_d   = '0;
				kind_d    = ixcs_pkg::KIND_OTHER;
				bidx_d    = '0;
				bstart_d  = '0;
				info_sc_d = '0;
				info_tc_d = '0;
				found_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ixcs_pkg::PH_HEADER;
			pos_q     <= '0;
			tag_q     <= '0;
			size_q    <= '0;
			bleft_q   <= '0;
			kind_q    <= ixcs_pkg::KIND_OTHER;
			bidx_q    <= '0;
			bstart_q  <= '0;
			info_sc_q <= '0;
			info_tc_q <= '0;
			found_q   <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			tag_q     <= tag_d;
			size_q    <= size_d;
			bleft_q   <= bleft_d;
			kind_q    <= kind_d;
			bidx_q    <= bidx_d;
			bstart_q  <= bstart_d;
			info_sc_q <= info_sc_d;
			info_tc_q <= info_tc_d;
			found_q   <= found_d;
		end
	end

	// Result records for this byte
	ixcs_pkg::rec_t seq_rec, sum_rec;
	logic [15:0]    sc_fin, tc_fin, found_fin;

	assign header_ok = (phase_u == ixcs_pkg::PH_CHDR) || (phase_u == ixcs_pkg::PH_BODY)
	                || (phase_u == ixcs_pkg::PH_STOP);
	assign sc_fin    = (phase_q == ixcs_pkg::PH_BODY && fourth && kind_q == ixcs_pkg::KIND_INFO)
	                 ? tag_sh[31:16] : info_sc_q;
	assign tc_fin    = (phase_q == ixcs_pkg::PH_BODY && fourth && kind_q == ixcs_pkg::KIND_INFO)
	                 ? tag_sh[15:0] : info_tc_q;
	assign found_fin = xmid_hit ? found_inc : found_q;

	always_comb begin
		seq_rec              = '0;
		seq_rec.record_kind  = ixcs_pkg::REC_SEQ;
		seq_rec.seq_offset   = 32'(bstart_q);
		seq_rec.seq_size     = size_q;
		seq_rec.last_result  = !byte_last;

		sum_rec              = '0;
		sum_rec.record_kind  = ixcs_pkg::REC_SUMMARY;
		sum_rec.file_valid   = header_ok && ((sc_fin != 16'd0) || (found_fin != 16'd0));
		sum_rec.seq_total    = sc_fin;
		sum_rec.timbre_total = tc_fin;
		sum_rec.seqs_found   = found_fin;
		sum_rec.last_result  = 1'b1;
	end

	// Sequence record goes first when both occur
	assign rec_a     = xmid_hit ? seq_rec : sum_rec;
	assign rec_b     = sum_rec;
	assign push.wr_a = xmid_hit || (byte_vld && byte_last);
	assign push.wr_b = xmid_hit && byte_last;

endmodule

// ----- design/ixcs_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ixcs_out_fifo
// Result queue. Takes up to two records per cycle, hands out one per
// transfer, and reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module ixcs_out_fifo #(
	parameter int DEPTH = ixcs_pkg::FIFO_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ixcs_pkg::push_t          push,
	input  ixcs_pkg::rec_t           rec_a,
	input  ixcs_pkg::rec_t           rec_b,
	input  logic                     pop,
	output logic                     not_empty,
	output ixcs_pkg::rec_t           head,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int AW = $clog2(DEPTH);

	ixcs_pkg::rec_t    mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       count_q;
	logic [AW:0]       n_push;
	logic              do_pop;

	assign n_push    = (AW+1)'(push.wr_a) + (AW+1)'(push.wr_b);
	assign do_pop    = pop && (count_q != '0);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rp_q];
	assign count     = count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push.wr_a) begin
			mem_q[wp_q] <= rec_a;
		end
		if (push.wr_b) begin
			mem_q[wp_q + AW'(1)] <= rec_b;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + n_push[AW-1:0];
			rp_q    <= rp_q + AW'(do_pop);
			count_q <= count_q + n_push - (AW+1)'(do_pop);
		end
	end

	// Second write only together with the first
	a_wr_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.wr_b |-> push.wr_a)
		else $error("second record written without first");

	// Writes never overrun the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.wr_a || push.wr_b) |-> ((count_q + n_push) <= (AW+1)'(DEPTH)))
		else $error("result queue overflow");

	// Fill level holds when nothing is pushed or popped
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!push.wr_a && !do_pop) |=> (count_q == $past(count_q)))
		else $error("fill level changed without transfer");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XMI chunk scanner. Whole IFF files are sent as
// byte transfers with random gaps on both channels; a scoreboard parses every
// accepted byte on its own and checks each result record, in order, field by
// field. Files are mostly well formed with random chunk content, mixed with
// broken headers, overruns, truncated files and odd length settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET = 1400;
	localparam int LONG_HOLD   = 400;
	localparam int IDLE_LIMIT  = 4000;

	// Scoreboard: own copy of the parser state, queue of records still due
	class scan_scoreboard;
		logic [31:0]      file_length;
		ixcs_pkg::phase_t phase;
		logic [63:0]      pos;
		logic [31:0]      tag_sr;
		logic [31:0]      size_sr;
		logic [31:0]      bytes_left;
		ixcs_pkg::kind_t  kind;
		int unsigned      body_idx;
		logic [63:0]      body_start;
		logic [15:0]      info_seqs;
		logic [15:0]      info_timbres;
		logic [15:0]      found;
		ixcs_pkg::rec_t   due_q[$];
		int               errors;

		function new();
			errors = 0;
			file_length = '0;
			restart();
		endfunction

		// Parser state after reset and after every last byte
		function void restart();
			phase = ixcs_pkg::PH_HEADER;
			pos = '0;
			tag_sr = '0;
			size_sr = '0;
			bytes_left = '0;
			kind = ixcs_pkg::KIND_OTHER;
			body_idx = 0;
			body_start = '0;
			info_seqs = '0;
			info_timbres = '0;
			found = '0;
		endfunction

		function void set_length(logic [31:0] v);
			file_length = v;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void push_rec(logic k, logic [31:0] off, logic [31:0] sz, logic v,
				logic [15:0] sc, logic [15:0] tc, logic [15:0] fc);
			ixcs_pkg::rec_t r;
			r.record_kind = k;
			r.seq_offset = off;
			r.seq_size = sz;
			r.file_valid = v;
			r.seq_total = sc;
			r.timbre_total = tc;
			r.seqs_found = fc;
			r.last_result = 1'b0;
			due_q.insert(due_q.size(), r);
		endfunction

		// Advance the parser by one accepted byte and queue what it causes
		function void note_byte(logic [7:0] b, logic is_last);
			logic [63:0]    flen;
			logic [31:0]    csize;
			logic           header_ok;
			int             n0;
			ixcs_pkg::rec_t r;
			flen = {32'd0, file_length};
			n0 = due_q.size();
			case (phase)
				ixcs_pkg::PH_HEADER: begin
					tag_sr = {tag_sr[23:0], b};
					if (pos == 3 && tag_sr != ixcs_pkg::TAG_FORM) begin
						phase = ixcs_pkg::PH_BAD;
					end else if (pos >= 11) begin
						if (tag_sr == ixcs_pkg::TAG_XDIR && flen >= 12) begin
							phase = ixcs_pkg::PH_CHDR;
							body_idx = 0;
						end else begin
							phase = ixcs_pkg::PH_BAD;
						end
					end
				end
				ixcs_pkg::PH_CHDR: begin
					// chunk header that no longer fits stops the scan
					if (body_idx == 0 && pos + 8 > flen) begin
						phase = ixcs_pkg::PH_STOP;
					end else begin
						if (body_idx < 4)
							tag_sr = {tag_sr[23:0], b};
						else
							size_sr = {size_sr[23:0], b};
						body_idx++;
						if (body_idx >= 8) begin
							csize = size_sr;
							body_start = pos + 1;
							body_idx = 0;
							if (body_start + csize > flen) begin
								phase = ixcs_pkg::PH_STOP;
							end else begin
								kind = ixcs_pkg::KIND_OTHER;
								if (csize >= 4) begin
									if (tag_sr == ixcs_pkg::TAG_INFO)
										kind = ixcs_pkg::KIND_INFO;
									else if (tag_sr == ixcs_pkg::TAG_FORM)
										kind = ixcs_pkg::KIND_FORM;
								end
								bytes_left = csize + csize[0];
								phase = (bytes_left == 0) ? ixcs_pkg::PH_CHDR
								                          : ixcs_pkg::PH_BODY;
							end
						end
					end
				end
				ixcs_pkg::PH_BODY: begin
					if (body_idx < 4) begin
						tag_sr = {tag_sr[23:0], b};
						body_idx++;
						if (body_idx == 4) begin
							if (kind == ixcs_pkg::KIND_INFO) begin
								info_seqs = tag_sr[31:16];
								info_timbres = tag_sr[15:0];
							end else if (kind == ixcs_pkg::KIND_FORM
									&& tag_sr == ixcs_pkg::TAG_XMID) begin
								push_rec(ixcs_pkg::REC_SEQ, body_start[31:0], size_sr, 1'b0,
									16'd0, 16'd0, 16'd0);
								if (found != 16'hFFFF)
									found++;
							end
						end
					end
					bytes_left--;
					if (bytes_left == 0) begin
						phase = ixcs_pkg::PH_CHDR;
						body_idx = 0;
					end
				end
				default: ;
			endcase

			if (pos < 64'hFFFF_FFFF)
				pos++;

			// end of file: summary, then back to the reset state
			if (is_last) begin
				header_ok = (phase == ixcs_pkg::PH_CHDR) || (phase == ixcs_pkg::PH_BODY)
				         || (phase == ixcs_pkg::PH_STOP);
				push_rec(ixcs_pkg::REC_SUMMARY, 32'd0, 32'd0,
					header_ok && (info_seqs != 0 || found != 0),
					info_seqs, info_timbres, found);
				restart();
			end

			if (due_q.size() > n0) begin
				r = due_q.pop_back();
				r.last_result = 1'b1;
				due_q.insert(due_q.size(), r);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Check one record taken from the output channel
		function void check_record(ixcs_pkg::rec_t got);
			ixcs_pkg::rec_t want;
			if (due_q.size() == 0) begin
				$display("%0t: expected no record, actual kind %0d offset 0x%0h",
					$time, got.record_kind, got.seq_offset);
				errors++;
				return;
			end
			want = due_q.pop_front();
			compare_field("record_kind", want.record_kind, got.record_kind);
			compare_field("seq_offset", want.seq_offset, got.seq_offset);
			compare_field("seq_size", want.seq_size, got.seq_size);
			compare_field("file_valid", want.file_valid, got.file_valid);
			compare_field("seq_total", want.seq_total, got.seq_total);
			compare_field("timbre_total", want.timbre_total, got.timbre_total);
			compare_field("seqs_found", want.seqs_found, got.seqs_found);
			compare_field("last_result", want.last_result, got.last_result);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        record_kind;
	logic [31:0] seq_offset;
	logic [31:0] seq_size;
	logic        file_valid;
	logic [15:0] seq_total;
	logic [15:0] timbre_total;
	logic [15:0] seqs_found;
	logic        last_result;

	scan_scoreboard sb;
	logic [7:0]     file_bytes[$];
	int             bytes_sent = 0;
	bit             no_gaps = 1'b0;
	bit             sink_steady = 1'b0;
	bit             hold_req = 1'b0;

	iff_xmi_chunk_scanner_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.record_kind  (record_kind),
		.seq_offset   (seq_offset),
		.seq_size     (seq_size),
		.file_valid   (file_valid),
		.seq_total    (seq_total),
		.timbre_total (timbre_total),
		.seqs_found   (seqs_found),
		.last_result  (last_result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_byte(logic [7:0] v);
		file_bytes.insert(file_bytes.size(), v);
	endfunction

	function automatic void push_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			add_byte(w[8*i +: 8]);
	endfunction

	// Build an IFF file: header, then random chunks
	function automatic void gen_file(int n_chunks, bit xmid_only);
		int unsigned sel;
		int unsigned body_len;
		logic [31:0] tag;
		logic [31:0] csize;
		file_bytes.delete();
		push_word(ixcs_pkg::TAG_FORM);
		push_word($urandom());
		push_word(ixcs_pkg::TAG_XDIR);
		// occasional corrupted header bit
		if (!xmid_only && $urandom_range(0, 11) == 0)
			file_bytes[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
		for (int c = 0; c < n_chunks; c++) begin
			sel = xmid_only ? 0 : $urandom_range(0, 9);
			case (sel)
				0, 1, 2, 3: begin
					tag = ixcs_pkg::TAG_FORM;
					csize = $urandom_range(4, 9);
				end
				4, 5: begin
					tag = ixcs_pkg::TAG_INFO;
					csize = $urandom_range(0, 8);
				end
				6: begin
					tag = ixcs_pkg::TAG_FORM;
					csize = $urandom_range(0, 9);
				end
				7: begin
					tag = $urandom();
					csize = $urandom_range(0, 10);
				end
				8: begin
					tag = ixcs_pkg::TAG_FORM;
					csize = $urandom_range(0, 3);
				end
				default: begin
					// oversized form, normally runs past the file end
					tag = ixcs_pkg::TAG_FORM;
					csize = $urandom();
				end
			endcase
			push_word(tag);
			push_word(csize);
			body_len = (sel == 9) ? $urandom_range(4, 12) : csize + csize[0];
			for (int i = 0; i < body_len; i++) begin
				if ((sel < 4 || sel == 8 || sel == 9) && i < 4)
					add_byte(8'(ixcs_pkg::TAG_XMID >> (24 - 8*i)));
				else
					add_byte(8'($urandom()));
			end
		end
	endfunction

	// One byte transfer; valid stays high into the next byte when no gap follows
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, is_last);
		bytes_sent++;
	endtask

	task automatic send_file(input int n);
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == n - 1);
	endtask

	// Sender off until every due record is back, plus pipeline slack
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_length(v);
	endtask

	// Main stimulus
	initial begin : stimulus
		int unsigned len;
		int unsigned n_send;
		int unsigned r;
		logic [31:0] flen;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// minimal file whose last byte ends an XMID tag: record then summary
		file_bytes.delete();
		push_word(ixcs_pkg::TAG_FORM);
		push_word(32'h00FF_FF00);
		push_word(ixcs_pkg::TAG_XDIR);
		push_word(ixcs_pkg::TAG_FORM);
		push_word(32'd4);
		push_word(ixcs_pkg::TAG_XMID);
		write_length(32'd24);
		send_file(24);
		drain();

		// one-byte file at zero length
		write_length(32'd0);
		file_bytes.delete();
		add_byte(8'hFF);
		send_file(1);
		drain();

		// result queue fills while the sink holds off
		gen_file(20, 1'b1);
		write_length(file_bytes.size());
		no_gaps = 1'b1;
		hold_req = 1'b1;
		send_file(file_bytes.size());
		no_gaps = 1'b0;
		drain();

		// random files
		while (bytes_sent < BYTE_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			sink_steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			if (r == 0) begin
				// largest length, files back to back
				drain();
				write_length(32'hFFFF_FFFF);
				repeat ($urandom_range(2, 4)) begin
					gen_file($urandom_range(0, 5), 1'b0);
					send_file(file_bytes.size());
				end
			end else if (r == 1) begin
				// zero length: every header fails
				drain();
				write_length(32'd0);
				repeat (2) begin
					gen_file($urandom_range(0, 2), 1'b0);
					send_file($urandom_range(1, file_bytes.size()));
				end
			end else begin
				gen_file($urandom_range(0, 6), 1'b0);
				len = file_bytes.size();
				r = $urandom_range(0, 11);
				if (r == 7)
					flen = len + $urandom_range(1, 16);
				else if (r == 8)
					flen = $urandom_range(0, len - 1);
				else if (r == 9)
					flen = $urandom_range(0, 11);
				else if (r == 10)
					flen = $urandom();
				else
					flen = len;
				n_send = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len;
				drain();
				write_length(flen);
				send_file(n_send);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result sink: random stalls, one long hold-off on request
	initial begin : sink
		ixcs_pkg::rec_t got;
		int             stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.record_kind = record_kind;
				got.seq_offset = seq_offset;
				got.seq_size = seq_size;
				got.file_valid = file_valid;
				got.seq_total = seq_total;
				got.timbre_total = timbre_total;
				got.seqs_found = seqs_found;
				got.last_result = last_result;
				sb.check_record(got);
			end
			if (hold_req) begin
				stall = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = sink_steady ? 0 : pick_gap();
			end
		end
	end

	// Watchdog: too many cycles without any transfer
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- iff_xmi_chunk_scanner_unit.f -----
design/ixcs_pkg.sv
design/ixcs_parser.sv
design/ixcs_out_fifo.sv
design/iff_xmi_chunk_scanner_unit.sv
test/tb_top.sv
